// ===== hw/rtl/msb_first_bit_packer_top_defines.svh =====
// Assertion helpers for the checker file.
`ifndef MSB_FIRST_BIT_PACKER_TOP_DEFINES_SVH
`define MSB_FIRST_BIT_PACKER_TOP_DEFINES_SVH

// Antecedent true at one edge implies consequent at the next edge.
`define MFBP_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

// Antecedent true at an edge implies consequent at the same edge.
`define MFBP_ASSERT_SAME(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`endif

// ===== hw/rtl/mfbp_pkg.sv =====
`default_nettype none

package mfbp_pkg;

  localparam int MaxFieldBitsDef = 32;
  localparam int QueueDepth = 2;
  localparam int ValueW = 32;
  localparam logic [15:0] BufSizeRst = 16'd188;

  // input opcodes
  localparam logic [1:0] OPC_START = 2'd0;
  localparam logic [1:0] OPC_WRITE = 2'd1;
  localparam logic [1:0] OPC_ALIGN = 2'd2;

  typedef enum logic [1:0] {
    KIND_START,
    KIND_WRITE,
    KIND_ALIGN
  } kind_e;

  typedef struct packed {
    logic [7:0]  byte_value;
    logic [15:0] byte_index;
    logic        overflow;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mfbp_front.sv =====
`default_nettype none

module mfbp_front import mfbp_pkg::*; #(
  parameter int MaxFieldBits = MaxFieldBitsDef,
  parameter int CntW = $clog2(MaxFieldBits + 1)
) (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        opcode_i,
  input  logic [5:0]        bit_count_i,
  input  logic [ValueW-1:0] bit_value_i,
  input  logic              q_full_i,
  output logic              push_o,
  output kind_e             kind_o,
  output logic [CntW-1:0]   cnt_o,
  output logic [ValueW-1:0] value_o
);

  logic keep;

  assign in_stall_o = q_full_i;
  assign value_o    = bit_value_i;
  assign push_o     = in_valid_i && !q_full_i && keep;

  always_comb begin
    if (32'(bit_count_i) > MaxFieldBits) begin
      cnt_o = CntW'(MaxFieldBits);
    end else begin
      cnt_o = CntW'(bit_count_i);
    end
  end

  // drop unused opcodes and empty writes here; they leave no trace
  always_comb begin
    keep   = 1'b0;
    kind_o = KIND_START;
    case (opcode_i)
      OPC_START: begin
        keep   = 1'b1;
        kind_o = KIND_START;
      end
      OPC_WRITE: begin
        keep   = (bit_count_i != 6'd0);
        kind_o = KIND_WRITE;
      end
      OPC_ALIGN: begin
        keep   = 1'b1;
        kind_o = KIND_ALIGN;
      end
      default: begin
        keep   = 1'b0;
        kind_o = KIND_START;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mfbp_queue.sv =====
`default_nettype none

module mfbp_queue import mfbp_pkg::*; #(
  parameter int DataW = 8,
  parameter int Depth = QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [DataW-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [DataW-1:0] data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int FillW = $clog2(Depth + 1);

  logic [DataW-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             do_push, do_pop;

  assign full_o  = (fill_q == FillW'(Depth));
  assign empty_o = (fill_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mfbp_back.sv =====
`default_nettype none

module mfbp_back import mfbp_pkg::*; #(
  parameter int CntW = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i,
  input  logic              q_empty_i,
  input  kind_e             q_kind_i,
  input  logic [CntW-1:0]   q_cnt_i,
  input  logic [ValueW-1:0] q_value_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output result_t           res_o
);

  logic [15:0]       bsize_q, bsize_d;
  logic [7:0]        part_q, part_d;
  logic [2:0]        fill_q, fill_d;
  logic [15:0]       widx_q, widx_d;
  logic              work_valid_q, work_valid_d;
  kind_e             kind_q, kind_d;
  logic [CntW-1:0]   rem_q, rem_d;
  logic [ValueW-1:0] val_q, val_d;
  logic              out_valid_q, out_valid_d;
  result_t           res_q, res_d;

  logic            slot_free, done, complete;
  logic [3:0]      room, take, fill_sum;
  logic [CntW-1:0] room_w, take_w, rest;
  logic [7:0]      chunk, placed, mask;
  logic [8:0]      mask_w;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  // bits of the current field that fit into the byte under assembly
  always_comb begin
    room     = 4'd8 - {1'b0, fill_q};
    room_w   = CntW'(room);
    take_w   = (rem_q < room_w) ? rem_q : room_w;
    take     = take_w[3:0];
    rest     = rem_q - take_w;
    mask_w   = (9'd1 << take) - 9'd1;
    mask     = mask_w[7:0];
    chunk    = 8'(val_q >> rest) & mask;
    placed   = chunk << (room - take);
    fill_sum = {1'b0, fill_q} + take;
    complete = (fill_sum == 4'd8);
  end

  always_comb begin
    bsize_d      = cfg_we_i ? cfg_wdata_i : bsize_q;
    part_d       = part_q;
    fill_d       = fill_q;
    widx_d       = widx_q;
    rem_d        = rem_q;
    res_d        = res_q;
    out_valid_d  = out_valid_q && out_stall_i;
    done         = 1'b0;

    if (work_valid_q) begin
      case (kind_q)
        KIND_START: begin
          part_d = '0;
          fill_d = '0;
          widx_d = '0;
          done   = 1'b1;
        end
        KIND_ALIGN: begin
          if (fill_q != 3'd0 && widx_q < bsize_q) begin
            if (slot_free) begin
              res_d       = '{byte_value: part_q, byte_index: widx_q,
                              overflow: 1'b0, last: 1'b1};
              out_valid_d = 1'b1;
              part_d      = '0;
              fill_d      = '0;
              widx_d      = widx_q + 16'd1;
              done        = 1'b1;
            end
          end else begin
            done = 1'b1;
          end
        end
        KIND_WRITE: begin
          if (rem_q == '0) begin
            done = 1'b1;
          end else if (complete) begin
            // hold until the output register can take the byte
            if (slot_free) begin
              res_d       = '{byte_value: part_q | placed, byte_index: widx_q,
                              overflow: (widx_q >= bsize_q),
                              last: (rest < CntW'(8))};
              out_valid_d = 1'b1;
              part_d      = '0;
              fill_d      = '0;
              widx_d      = widx_q + 16'd1;
              rem_d       = rest;
              done        = (rest == '0);
            end
          end else begin
            part_d = part_q | placed;
            fill_d = fill_sum[2:0];
            rem_d  = rest;
            done   = 1'b1;
          end
        end
        default: begin
          done = 1'b1;
        end
      endcase
    end
  end

  assign pop_o = !q_empty_i && (!work_valid_q || done);

  always_comb begin
    kind_d       = kind_q;
    val_d        = val_q;
    work_valid_d = work_valid_q && !done;
    if (pop_o) begin
      work_valid_d = 1'b1;
      kind_d       = q_kind_i;
      val_d        = q_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bsize_q      <= BufSizeRst;
      part_q       <= '0;
      fill_q       <= '0;
      widx_q       <= '0;
      work_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      bsize_q      <= bsize_d;
      part_q       <= part_d;
      fill_q       <= fill_d;
      widx_q       <= widx_d;
      work_valid_q <= work_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    val_q  <= val_d;
    rem_q  <= pop_o ? q_cnt_i : rem_d;
    res_q  <= res_d;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/msb_first_bit_packer_top.sv =====
// Channel   Direction  Handshake              Beat contents
// input     in         in_valid_i/in_stall_o  opcode_i, bit_count_i, bit_value_i
// output    out        out_valid_o/out_stall_i byte_value_o, byte_index_o,
//                                              overflow_o, last_o
// config    in         cfg_we_i               cfg_wdata_i (buffer size)
//
// An input beat enters a two-entry queue in the cycle it is accepted; the back
// end loads it into its work registers once the current item is done, then
// takes the field chunk by chunk, each chunk being the bits that fit the byte
// under assembly, with at most one output byte per cycle through the output
// register. Reset is asynchronous and active low; buffer size returns to 188.
// Output stall holds the back end only when a finished byte needs the output
// register; the queue keeps accepting input until it is full.
`default_nettype none

module msb_first_bit_packer_top import mfbp_pkg::*; #(
  parameter int MaxFieldBits = MaxFieldBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        opcode_i,
  input  logic [5:0]        bit_count_i,
  input  logic [ValueW-1:0] bit_value_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        byte_value_o,
  output logic [15:0]       byte_index_o,
  output logic              overflow_o,
  output logic              last_o
);

  localparam int CntW = $clog2(MaxFieldBits + 1);
  localparam int EntryW = $bits(kind_e) + CntW + ValueW;

  logic              push, q_full, q_empty, pop;
  kind_e             f_kind, q_kind;
  logic [CntW-1:0]   f_cnt, q_cnt;
  logic [ValueW-1:0] f_value, q_value;
  logic [EntryW-1:0] q_wdata, q_rdata;
  result_t           res;

  mfbp_front #(
    .MaxFieldBits(MaxFieldBits),
    .CntW        (CntW)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .opcode_i   (opcode_i),
    .bit_count_i(bit_count_i),
    .bit_value_i(bit_value_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .kind_o     (f_kind),
    .cnt_o      (f_cnt),
    .value_o    (f_value)
  );

  assign q_wdata = {f_kind, f_cnt, f_value};

  mfbp_queue #(
    .DataW(EntryW),
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (q_wdata),
    .full_o (q_full),
    .pop_i  (pop),
    .empty_o(q_empty),
    .data_o (q_rdata)
  );

  assign q_kind  = kind_e'(q_rdata[EntryW-1 -: $bits(kind_e)]);
  assign q_cnt   = q_rdata[ValueW +: CntW];
  assign q_value = q_rdata[ValueW-1:0];

  mfbp_back #(
    .CntW(CntW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .q_empty_i  (q_empty),
    .q_kind_i   (q_kind),
    .q_cnt_i    (q_cnt),
    .q_value_i  (q_value),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .res_o      (res)
  );

  assign byte_value_o = res.byte_value;
  assign byte_index_o = res.byte_index;
  assign overflow_o   = res.overflow;
  assign last_o       = res.last;

endmodule

`default_nettype wire

// ===== hw/rtl/mfbp_checker.sv =====
`default_nettype none
`include "msb_first_bit_packer_top_defines.svh"

module mfbp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  byte_value_o,
  input logic [15:0] byte_index_o,
  input logic        overflow_o,
  input logic        last_o
);

  logic [25:0] beat;

  assign beat = {byte_value_o, byte_index_o, overflow_o, last_o};

  `MFBP_ASSERT_NEXT(a_valid_held, out_valid_o && out_stall_i, out_valid_o, "beat dropped under stall")

  `MFBP_ASSERT_NEXT(a_beat_held, out_valid_o && out_stall_i, $stable(beat), "beat changed under stall")

  `MFBP_ASSERT_SAME(a_beat_known, out_valid_o, !$isunknown(beat), "unknown bits in output beat")

  // a byte that is not the last of its item is followed at once by the next one
  `MFBP_ASSERT_NEXT(a_burst_gapless, out_valid_o && !out_stall_i && !last_o, out_valid_o, "gap in burst")

  `MFBP_ASSERT_NEXT(a_burst_index, out_valid_o && !out_stall_i && !last_o,
                    byte_index_o == $past(byte_index_o) + 16'd1, "index skipped in burst")

endmodule

bind msb_first_bit_packer_top mfbp_checker u_mfbp_checker (.*);

`default_nettype wire
